>>> hdl/grid_bfs_shortest_path_macros.svh
// Assertion macros for the grid BFS block.
`ifndef GRID_BFS_SHORTEST_PATH_MACROS_SVH
`define GRID_BFS_SHORTEST_PATH_MACROS_SVH
`ifndef SYNTHESIS
`define GBSP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define GBSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define GBSP_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define GBSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> hdl/gbsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gbsp_pkg;
   localparam logic [1:0] PH_LOADING = 2'd0;
   localparam logic [1:0] PH_TRACE   = 2'd1;
   localparam logic [1:0] PH_DONE    = 2'd2;
   localparam logic       KIND_LOAD  = 1'b0;
   localparam logic       KIND_READ  = 1'b1;
   localparam logic       CSR_ROWS   = 1'b0;
   localparam logic       CSR_COLS   = 1'b1;
   localparam int         NUM_DIRS   = 8;
   typedef logic [2:0] dir_type;

   // Row step per direction: up, up-left, left, down-left, down, down-right, right, up-right.
   function automatic logic signed [1:0] step_r(input dir_type d);
      logic signed [1:0] s;
      begin
         case (d)
            3'd0, 3'd1, 3'd7: s = -2'sd1;
            3'd3, 3'd4, 3'd5: s = 2'sd1;
            default:          s = 2'sd0;
         endcase
         return s;
      end
   endfunction

   function automatic logic signed [1:0] step_c(input dir_type d);
      logic signed [1:0] s;
      begin
         case (d)
            3'd1, 3'd2, 3'd3: s = -2'sd1;
            3'd5, 3'd6, 3'd7: s = 2'sd1;
            default:          s = 2'sd0;
         endcase
         return s;
      end
   endfunction
endpackage
`default_nettype wire

>>> hdl/grid_bfs_shortest_path.sv
`timescale 1ns / 1ps
`default_nettype none
// Lee maze router, 8-connected BFS over one level memory and one cell FIFO memory.
// Load item: no result. The last load starts the wave after the S_W_INIT setup state;
// each dequeued cell has its level read and its on-grid neighbours checked; busy meanwhile.
// Read item: no result while loading; on a trace the strobe follows S_T_RDCUR, S_T_CURLV
// then S_T_NB/S_T_NBCHK per neighbour tried; a no-path answer is registered; receiver cannot stall.
// Reset (synchronous, high): loading phase, counts cleared, rows/cols = 8; memories undefined.
module grid_bfs_shortest_path
   import gbsp_pkg::*;
#(
   parameter int MAX_ROWS = 32,
   parameter int MAX_COLS = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic       req_kind,
   input  wire logic       req_wall,
   output logic            rsp_valid,
   output logic [5:0]      rsp_row,
   output logic [5:0]      rsp_col,
   output logic            rsp_last,
   output logic            rsp_no_path,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_index,
   input  wire logic [5:0] csr_data
);
`include "grid_bfs_shortest_path_macros.svh"

   localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int AW    = RW + CW;
   localparam int CELLS = MAX_ROWS * MAX_COLS;
   localparam int MEMD  = 2 ** AW;
   localparam int QW    = $clog2(CELLS + 1);
   localparam int LW    = $clog2(CELLS + 3);
   localparam int DW    = 9;

   typedef enum logic [3:0] {
      S_IDLE, S_W_INIT, S_W_RDCUR, S_W_CURLV, S_W_NB, S_W_NBCHK,
      S_W_DEQ, S_W_DEQWT, S_T_RDCUR, S_T_CURLV, S_T_NB, S_T_NBCHK
   } state_type;

   state_type        state_ff;
   logic [1:0]       phase_ff;
   logic [5:0]       rows_ff, cols_ff;
   logic [QW-1:0]    load_cnt_ff;
   logic [RW-1:0]    load_r_ff, r_ff, nr_ff;
   logic [CW-1:0]    load_c_ff, c_ff, nc_ff;
   logic [DW-1:0]    act_rows_ff, act_cols_ff;
   logic [QW-1:0]    head_ff, tail_ff;
   logic [LW-1:0]    lv_ff;
   dir_type          dir_ff;

   logic [LW-1:0]    lvl_mem [MEMD];
   logic [AW-1:0]    fifo_mem [MEMD];
   logic [LW-1:0]    lvl_q;
   logic [AW-1:0]    fifo_q;
   logic             lvl_we;
   logic [AW-1:0]    lvl_waddr, lvl_raddr;
   logic [LW-1:0]    lvl_wdata;
   logic             fifo_we;

   // Clamp the configured size into 1..MAX.
   function automatic logic [DW-1:0] clampd(input logic [5:0] v, input int mx);
      logic [DW-1:0] r;
      begin
         if (v == 6'd0) r = DW'(1);
         else if (int'(v) > mx) r = DW'(mx);
         else r = DW'(v);
         return r;
      end
   endfunction

   logic [DW-1:0] cur_rows, cur_cols;
   assign cur_rows = clampd(rows_ff, MAX_ROWS);
   assign cur_cols = clampd(cols_ff, MAX_COLS);

   // Neighbour of the current cell in direction dir_ff, against the latched size.
   logic signed [DW+1:0] nbr_s, nbc_s;
   logic                 nb_ok;
   assign nbr_s = $signed({2'b00, DW'(r_ff)}) + (DW+2)'(step_r(dir_ff));
   assign nbc_s = $signed({2'b00, DW'(c_ff)}) + (DW+2)'(step_c(dir_ff));
   assign nb_ok = (nbr_s >= 0) && (nbc_s >= 0) &&
                  (nbr_s < $signed({2'b00, act_rows_ff})) &&
                  (nbc_s < $signed({2'b00, act_cols_ff}));

   logic at_exit;
   assign at_exit = (DW'(r_ff) == act_rows_ff - DW'(1)) &&
                    (DW'(c_ff) == act_cols_ff - DW'(1));

   logic accept;
   assign accept = start && !busy;
   assign busy = (state_ff != S_IDLE);
   // Hold size writes off while a maze is partly loaded so the row-major walk stays valid.
   assign csr_ready = (state_ff == S_IDLE) && !start && (load_cnt_ff == '0);

   // Result strobe for the next cycle: no-path answers, start cell, end of a trace step.
   logic rsp_valid_in;
   always_comb begin
      rsp_valid_in = 1'b0;
      if (state_ff == S_IDLE) begin
         rsp_valid_in = accept && req_kind == KIND_READ && phase_ff == PH_DONE;
      end else if (state_ff == S_T_CURLV) begin
         rsp_valid_in = (r_ff == '0) && (c_ff == '0);
      end else if (state_ff == S_T_NB) begin
         rsp_valid_in = !nb_ok && (dir_ff == dir_type'(NUM_DIRS-1));
      end else if (state_ff == S_T_NBCHK) begin
         rsp_valid_in = (lvl_q == lv_ff - LW'(1)) || (dir_ff == dir_type'(NUM_DIRS-1));
      end
   end

   // Memory ports: read address chosen by state, write for loads, the start cell and visits.
   always_comb begin
      lvl_raddr = {r_ff, c_ff};
      if (state_ff == S_W_NB || state_ff == S_T_NB) lvl_raddr = {nbr_s[RW-1:0], nbc_s[CW-1:0]};
      lvl_we    = 1'b0;
      lvl_waddr = {nr_ff, nc_ff};
      lvl_wdata = lv_ff + LW'(1);
      fifo_we   = 1'b0;
      if (state_ff == S_IDLE && accept && req_kind == KIND_LOAD) begin
         lvl_we    = 1'b1;
         lvl_waddr = {load_r_ff, load_c_ff};
         lvl_wdata = LW'(req_wall);
      end else if (state_ff == S_W_INIT) begin
         lvl_we    = 1'b1;
         lvl_waddr = '0;
         lvl_wdata = LW'(2);
      end else if (state_ff == S_W_NBCHK && lvl_q == '0) begin
         lvl_we  = 1'b1;
         fifo_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (lvl_we) lvl_mem[lvl_waddr] <= lvl_wdata;
      lvl_q <= lvl_mem[lvl_raddr];
      if (fifo_we) fifo_mem[tail_ff[AW-1:0]] <= {nr_ff, nc_ff};
      fifo_q <= fifo_mem[head_ff[AW-1:0]];
   end

   logic [2*DW-1:0] total;
   logic            load_fin;
   assign total    = cur_rows * cur_cols;
   assign load_fin = ((2*DW)'(load_cnt_ff) + (2*DW)'(1)) >= total;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         phase_ff    <= PH_LOADING;
         rows_ff     <= 6'd8;
         cols_ff     <= 6'd8;
         load_cnt_ff <= '0;
         load_r_ff   <= '0;
         load_c_ff   <= '0;
         head_ff     <= '0;
         tail_ff     <= '0;
         rsp_valid   <= 1'b0;
         rsp_row     <= '0;
         rsp_col     <= '0;
         rsp_last    <= 1'b0;
         rsp_no_path <= 1'b0;
         act_rows_ff <= DW'(8);
         act_cols_ff <= DW'(8);
         r_ff <= '0; c_ff <= '0; nr_ff <= '0; nc_ff <= '0;
         lv_ff <= '0; dir_ff <= '0;
      end else begin
         rsp_valid <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_ROWS) rows_ff <= csr_data;
            else cols_ff <= csr_data;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept && req_kind == KIND_LOAD) begin
                  // Walk row-major with the current sizes; the count restarts on the last load of a maze.
                  if (phase_ff != PH_LOADING) begin
                     // Wave is over: this cell starts a new maze at cell 0.
                     phase_ff <= PH_LOADING;
                  end
                  if (load_fin) begin
                     load_cnt_ff <= '0;
                     load_r_ff   <= '0;
                     load_c_ff   <= '0;
                     act_rows_ff <= cur_rows;
                     act_cols_ff <= cur_cols;
                     state_ff    <= S_W_INIT;
                  end else begin
                     load_cnt_ff <= load_cnt_ff + QW'(1);
                     if (DW'(load_c_ff) == cur_cols - DW'(1)) begin
                        load_c_ff <= '0;
                        load_r_ff <= load_r_ff + RW'(1);
                     end else begin
                        load_c_ff <= load_c_ff + CW'(1);
                     end
                  end
               end else if (accept && req_kind == KIND_READ) begin
                  if (phase_ff == PH_DONE) begin
                     rsp_row     <= '0;
                     rsp_col     <= '0;
                     rsp_last    <= 1'b1;
                     rsp_no_path <= 1'b1;
                  end else if (phase_ff == PH_TRACE) begin
                     state_ff <= S_T_RDCUR;
                  end
               end
            end
            S_W_INIT: begin
               head_ff <= '0; tail_ff <= '0;
               r_ff <= '0; c_ff <= '0;
               state_ff <= S_W_RDCUR;
            end
            S_W_RDCUR: begin
               if (at_exit) begin
                  phase_ff <= PH_TRACE;
                  state_ff <= S_IDLE;
               end else state_ff <= S_W_CURLV;
            end
            S_W_CURLV: begin
               lv_ff <= lvl_q;
               dir_ff <= '0;
               state_ff <= S_W_NB;
            end
            S_W_NB: begin
               nr_ff <= nbr_s[RW-1:0];
               nc_ff <= nbc_s[CW-1:0];
               if (nb_ok) state_ff <= S_W_NBCHK;
               else if (dir_ff == dir_type'(NUM_DIRS-1)) state_ff <= S_W_DEQ;
               else dir_ff <= dir_ff + dir_type'(1);
            end
            S_W_NBCHK: begin
               if (lvl_q == '0) tail_ff <= tail_ff + QW'(1);
               if (dir_ff == dir_type'(NUM_DIRS-1)) state_ff <= S_W_DEQ;
               else begin
                  dir_ff <= dir_ff + dir_type'(1);
                  state_ff <= S_W_NB;
               end
            end
            S_W_DEQ: begin
               if (head_ff == tail_ff) begin
                  phase_ff <= PH_DONE;
                  state_ff <= S_IDLE;
               end else state_ff <= S_W_DEQWT;
            end
            S_W_DEQWT: begin
               r_ff <= fifo_q[AW-1:CW];
               c_ff <= fifo_q[CW-1:0];
               head_ff <= head_ff + QW'(1);
               state_ff <= S_W_RDCUR;
            end
            S_T_RDCUR: state_ff <= S_T_CURLV;
            S_T_CURLV: begin
               lv_ff <= lvl_q;
               dir_ff <= '0;
               rsp_row <= 6'(DW'(r_ff) + DW'(1));
               rsp_col <= 6'(DW'(c_ff) + DW'(1));
               rsp_no_path <= 1'b0;
               if (r_ff == '0 && c_ff == '0) begin
                  rsp_last  <= 1'b1;
                  phase_ff  <= PH_DONE;
                  state_ff  <= S_IDLE;
               end else state_ff <= S_T_NB;
            end
            S_T_NB: begin
               nr_ff <= nbr_s[RW-1:0];
               nc_ff <= nbc_s[CW-1:0];
               if (nb_ok) state_ff <= S_T_NBCHK;
               else if (dir_ff == dir_type'(NUM_DIRS-1)) begin
                  rsp_last  <= 1'b1;
                  phase_ff  <= PH_DONE;
                  state_ff  <= S_IDLE;
               end else dir_ff <= dir_ff + dir_type'(1);
            end
            S_T_NBCHK: begin
               if (lvl_q == lv_ff - LW'(1)) begin
                  r_ff <= nr_ff;
                  c_ff <= nc_ff;
                  rsp_last  <= 1'b0;
                  state_ff  <= S_IDLE;
               end else if (dir_ff == dir_type'(NUM_DIRS-1)) begin
                  rsp_last  <= 1'b1;
                  phase_ff  <= PH_DONE;
                  state_ff  <= S_IDLE;
               end else begin
                  dir_ff <= dir_ff + dir_type'(1);
                  state_ff <= S_T_NB;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `GBSP_ASSERT_IMPL(a_rsp_only_idle_next, clock, reset, rsp_valid, state_ff == S_IDLE, "result outside idle")
   `GBSP_ASSERT_NEXT(a_busy_after_trace, clock, reset, accept && req_kind == KIND_READ && phase_ff == PH_TRACE, busy, "trace read not started")
   `GBSP_ASSERT_IMPL(a_fifo_order, clock, reset, busy, head_ff <= tail_ff, "fifo head passed tail")
   `GBSP_ASSERT_NEXT(a_done_answer, clock, reset, accept && req_kind == KIND_READ && phase_ff == PH_DONE, rsp_valid && rsp_no_path, "done answer missing")

endmodule
`default_nettype wire
